// ----- design/ifft_pkg.sv -----
package ifft_pkg;

    // Transform size and number formats
    localparam int POINTS        = 1024;
    localparam int SAMPLE_BITS   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int IN_BITS       = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
    localparam int LOG_POINTS    = $clog2(POINTS);
    localparam int TW_DEPTH      = POINTS / 2;
    localparam int TW_BITS       = LOG_POINTS - 1;
    localparam int STAGE_BITS    = $clog2(LOG_POINTS);

    typedef logic [LOG_POINTS-1:0]  addr_t;
    typedef logic [LOG_POINTS:0]    count_t;
    typedef logic [TW_BITS-1:0]     tw_addr_t;
    typedef logic [TW_BITS-1:0]     bfly_t;
    typedef logic [STAGE_BITS-1:0]  stage_t;
    typedef logic signed [31:0]     tw_t;
    typedef logic signed [63:0]     acc_t;
    typedef logic [IN_BITS-1:0]     smp_t;
    typedef tw_t                    tw_rom_t [TW_DEPTH];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_REV,
        ST_BF_RD,
        ST_BF_START,
        ST_BF_MUL,
        ST_BF_WLO,
        ST_BF_WHI
    } state_t;

    localparam acc_t ACC_MAX = {1'b0, {63{1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {63{1'b0}}};

    // Series divisors for the twiddle build: sine (2n)(2n+1), cosine (2n-1)(2n)
    localparam logic [63:0] SIN_DIV [24] = '{
        64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
        64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056,
        64'd1190, 64'd1332, 64'd1482, 64'd1640, 64'd1806, 64'd1980, 64'd2162};
    localparam logic [63:0] COS_DIV [24] = '{
        64'd1, 64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240,
        64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756, 64'd870, 64'd992,
        64'd1122, 64'd1260, 64'd1406, 64'd1560, 64'd1722, 64'd1892, 64'd2070};
    localparam logic [63:0] PI_Q32 = 64'h0000_0003_243F_6A89;

    function automatic acc_t sat_add(input acc_t a, input acc_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            sat_add = s[64] ? ACC_MIN : ACC_MAX;
        else
            sat_add = s[63:0];
    endfunction

    function automatic acc_t sat_sub(input acc_t a, input acc_t b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            sat_sub = s[64] ? ACC_MIN : ACC_MAX;
        else
            sat_sub = s[63:0];
    endfunction

    function automatic addr_t bit_rev(input addr_t a);
        addr_t r;
        for (int b = 0; b < LOG_POINTS; b++)
        begin
            r[LOG_POINTS-1-b] = a[b];
        end
        return r;
    endfunction

    // Q63 product, bits 126..63 of the full product
    function automatic logic [63:0] mul_q63(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[126:63];
    endfunction

    function automatic tw_rom_t build_tw(input bit want_sin);
        tw_rom_t     rom;
        logic [63:0] p, a, bb, x, x2, ts, ss, tc, sc;
        logic [1:0]  q;
        logic        swap;
        tw_t         c0, s0, t;
        for (int k = 0; k < TW_DEPTH; k++)
        begin
            p    = (64'(k) << (32 - LOG_POINTS)) & 64'hFFFF_FFFF;
            q    = p[31:30];
            a    = p & 64'h3FFF_FFFF;
            swap = a > (64'd1 << 29);
            bb   = swap ? (64'd1 << 30) - a : a;
            x    = bb * PI_Q32;
            x2   = mul_q63(x, x);
            ts   = x;
            ss   = x;
            tc   = 64'd1 << 63;
            sc   = 64'd1 << 63;
            for (int n = 1; n < 24; n++)
            begin
                ts = mul_q63(ts, x2) / SIN_DIV[n];
                tc = mul_q63(tc, x2) / COS_DIV[n];
                if (n % 2 == 1)
                begin
                    ss = ss - ts;
                    sc = sc - tc;
                end
                else
                begin
                    ss = ss + ts;
                    sc = sc + tc;
                end
            end
            s0 = tw_t'((ss + (64'd1 << 32)) >> 33);
            c0 = tw_t'((sc + (64'd1 << 32)) >> 33);
            if (swap)
            begin
                t  = c0;
                c0 = s0;
                s0 = t;
            end
            case (q)
                2'd0:    rom[k] = want_sin ? s0 : c0;
                2'd1:    rom[k] = want_sin ? c0 : -s0;
                2'd2:    rom[k] = want_sin ? -s0 : -c0;
                default: rom[k] = want_sin ? -c0 : s0;
            endcase
        end
        return rom;
    endfunction

    localparam tw_rom_t TW_COS = build_tw(1'b0);
    localparam tw_rom_t TW_SIN = build_tw(1'b1);

endpackage

// ----- design/ifft_if.sv -----
interface ifft_in_if
    import ifft_pkg::*;
();
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_real;
    logic signed [31:0] sample_imag;
    logic               flush;

    modport source (output valid, sample_real, sample_imag, flush, input ready);
    modport sink   (input valid, sample_real, sample_imag, flush, output ready);
endinterface

interface ifft_out_if
    import ifft_pkg::*;
();
    logic               valid;
    logic               ready;
    logic signed [63:0] out_real;
    logic signed [63:0] out_imag;
    logic               out_last;

    modport source (output valid, out_real, out_imag, out_last, input ready);
    modport sink   (input valid, out_real, out_imag, out_last, output ready);
endinterface

// ----- design/ifft_cmul.sv -----
module ifft_cmul
    import ifft_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  acc_t xr,
    input  acc_t xi,
    input  tw_t  c,
    input  tw_t  s,
    output logic done,
    output acc_t tr,
    output acc_t ti
);

    localparam int MUL_STEPS = 8;
    typedef logic [3:0] step_t;

    logic        busy_reg;
    logic        done_reg;
    step_t       cnt_reg;
    logic [63:0] mag_xr_reg, mag_xi_reg;
    logic [31:0] mag_c_reg, mag_s_reg;
    logic        neg_xr_reg, neg_xi_reg, neg_c_reg, neg_s_reg;
    logic [63:0] prod_reg;
    logic [63:0] lo_reg;
    acc_t        mt_reg [4];
    acc_t        tr_reg, ti_reg;

    logic [1:0]  op_idx, proc_idx;
    step_t       proc_step;
    logic [63:0] op_m;
    logic [31:0] op_a, op_u;
    logic [63:0] prod_w;
    logic [63:0] r_w;
    logic        neg_w;
    acc_t        mt_w;

    function automatic logic [63:0] abs64(input acc_t v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Pick the operand half for this step: lo half on even steps, hi half on odd
    always_comb
    begin
        op_idx = cnt_reg[2:1];
        op_m   = (op_idx == 2'd0 || op_idx == 2'd3) ? mag_xr_reg : mag_xi_reg;
        op_u   = (op_idx == 2'd0 || op_idx == 2'd2) ? mag_c_reg : mag_s_reg;
        op_a   = cnt_reg[0] ? op_m[63:32] : op_m[31:0];
        prod_w = op_a * op_u;
    end

    // Round, combine and saturate the product of the previous step
    always_comb
    begin
        proc_step = cnt_reg - step_t'(1);
        proc_idx  = proc_step[2:1];
        case (proc_idx)
            2'd0:    neg_w = neg_xr_reg ^ neg_c_reg;
            2'd1:    neg_w = neg_xi_reg ^ neg_s_reg;
            2'd2:    neg_w = neg_xi_reg ^ neg_c_reg;
            default: neg_w = neg_xr_reg ^ neg_s_reg;
        endcase
        r_w = {prod_reg[61:0], 2'b00} + lo_reg;
        if (!neg_w)
            mt_w = r_w[63] ? ACC_MAX : acc_t'(r_w);
        else
            mt_w = r_w[63] ? ACC_MIN : acc_t'(-r_w);
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + step_t'(1);
                if (cnt_reg == step_t'(MUL_STEPS + 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: latch magnitudes, multiply, accumulate
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_xr_reg <= abs64(xr);
            mag_xi_reg <= abs64(xi);
            mag_c_reg  <= 32'(abs64(acc_t'(c)));
            mag_s_reg  <= 32'(abs64(acc_t'(s)));
            neg_xr_reg <= xr[63];
            neg_xi_reg <= xi[63];
            neg_c_reg  <= c[31];
            neg_s_reg  <= s[31];
        end
        else if (busy_reg)
        begin
            if (cnt_reg < step_t'(MUL_STEPS))
                prod_reg <= prod_w;
            if (cnt_reg != '0 && cnt_reg <= step_t'(MUL_STEPS))
            begin
                if (!proc_step[0])
                    lo_reg <= (prod_reg + (64'd1 << 29)) >> 30;
                else
                    mt_reg[proc_idx] <= mt_w;
            end
            if (cnt_reg == step_t'(MUL_STEPS + 1))
            begin
                tr_reg <= sat_sub(mt_reg[0], mt_reg[1]);
                ti_reg <= sat_add(mt_reg[2], mt_reg[3]);
            end
        end
    end

    assign done = done_reg;
    assign tr   = tr_reg;
    assign ti   = ti_reg;

endmodule

// ----- design/inverse_fft_radix2.sv -----
// Streaming radix-2 inverse FFT, POINTS complex samples per frame.
// sample_in: one beat carries a complex integer sample, or a flush beat that
// carries no sample and only pulls out a held result.
// result_out: one transformed sample per accepted input beat while a finished
// frame is held, in natural order, out_last on the final sample of the frame.
// Values are fixed point with FRACTION_BITS fraction bits, saturated to 64 bits.
// A beat that emits is accepted with a result memory read, then ST_FETCH loads
// the read value into the output register; a beat that emits nothing is only
// accepted. The beat that completes a frame then starts the transform: a
// bit-reversed copy, then (POINTS/2)*log2(POINTS) butterflies on one shared
// multiplier (eight 32x32 partial products per butterfly, two writes, low then
// high, on the single result write port). Ready stays low meanwhile.
// Reset clears the positions and the held-frame flag; the buffers need no
// clearing. A stalled receiver holds the output register; a new beat that
// would emit waits until that register frees.
module inverse_fft_radix2
    import ifft_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    ifft_in_if.sink     sample_in,
    ifft_out_if.source  result_out
);

    state_t   state_reg, state_next;
    addr_t    load_pos_reg;
    addr_t    emit_pos_reg;
    logic     result_ready_reg;
    logic     go_xform_reg;
    count_t   rev_cnt_reg;
    bfly_t    bf_cnt_reg;
    stage_t   stage_reg;
    logic     out_valid_reg;
    logic     last_pend_reg;
    acc_t     out_real_reg, out_imag_reg;
    logic     out_last_reg;

    logic [2*IN_BITS-1:0] load_mem [POINTS];
    logic [127:0]         res_mem  [POINTS];
    logic [2*IN_BITS-1:0] ld_rd_reg;
    logic [127:0]         rd_a_reg, rd_b_reg;
    tw_t                  tw_c_reg, tw_s_reg;

    logic     accept, emitting, frame_done, emit_last;
    logic     rd_a_en, rd_b_en, wr_en, mul_start, mul_done;
    addr_t    rd_a_addr, wr_addr, lo_addr, hi_addr, half_mask, bx;
    tw_addr_t tw_idx;
    logic [127:0] wr_data;
    acc_t     ur, ui, tr, ti, rev_re, rev_im;
    logic     stage_end, xform_end;

    // Butterfly addressing: insert a zero bit at the stage position
    always_comb
    begin
        half_mask = (addr_t'(1) << stage_reg) - addr_t'(1);
        bx        = addr_t'(bf_cnt_reg);
        lo_addr   = ((bx & ~half_mask) << 1) | (bx & half_mask);
        hi_addr   = lo_addr | (addr_t'(1) << stage_reg);
        tw_idx    = tw_addr_t'((bx & half_mask) << (TW_BITS - int'(stage_reg)));
        stage_end = bf_cnt_reg == '1;
        xform_end = stage_end && (stage_reg == stage_t'(LOG_POINTS - 1));
    end

    assign accept     = sample_in.valid && sample_in.ready;
    assign emitting   = accept && result_ready_reg;
    assign frame_done = accept && !sample_in.flush && (load_pos_reg == addr_t'(POINTS - 1));
    assign emit_last  = emit_pos_reg == addr_t'(POINTS - 1);

    assign ur = acc_t'(rd_a_reg[127:64]);
    assign ui = acc_t'(rd_a_reg[63:0]);
    assign rev_re = acc_t'(signed'(ld_rd_reg[2*IN_BITS-1:IN_BITS])) <<< FRACTION_BITS;
    assign rev_im = acc_t'(signed'(ld_rd_reg[IN_BITS-1:0])) <<< FRACTION_BITS;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (emitting)
                    state_next = ST_FETCH;
                else if (frame_done)
                    state_next = ST_REV;
            end
            ST_FETCH:    state_next = go_xform_reg ? ST_REV : ST_IDLE;
            ST_REV:
            begin
                if (rev_cnt_reg == count_t'(POINTS))
                    state_next = ST_BF_RD;
            end
            ST_BF_RD:    state_next = ST_BF_START;
            ST_BF_START: state_next = ST_BF_MUL;
            ST_BF_MUL:
            begin
                if (mul_done)
                    state_next = ST_BF_WLO;
            end
            ST_BF_WLO:   state_next = ST_BF_WHI;
            ST_BF_WHI:   state_next = xform_end ? ST_IDLE : ST_BF_RD;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control outputs and memory port selection
    always_comb
    begin
        sample_in.ready = 1'b0;
        rd_a_en   = 1'b0;
        rd_b_en   = 1'b0;
        rd_a_addr = emit_pos_reg;
        wr_en     = 1'b0;
        wr_addr   = lo_addr;
        wr_data   = {sat_add(ur, tr), sat_add(ui, ti)};
        mul_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_in.ready = !(result_ready_reg && out_valid_reg && !result_out.ready);
                rd_a_en = emitting;
            end
            ST_REV:
            begin
                wr_en   = rev_cnt_reg != '0;
                wr_addr = bit_rev(addr_t'(rev_cnt_reg - count_t'(1)));
                wr_data = {rev_re, rev_im};
            end
            ST_BF_RD:
            begin
                rd_a_en   = 1'b1;
                rd_b_en   = 1'b1;
                rd_a_addr = lo_addr;
            end
            ST_BF_START: mul_start = 1'b1;
            ST_BF_WLO:   wr_en = 1'b1;
            ST_BF_WHI:
            begin
                wr_en   = 1'b1;
                wr_addr = hi_addr;
                wr_data = {sat_sub(ur, tr), sat_sub(ui, ti)};
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // Sample buffer: write on accepted sample beats, read during the copy
    always_ff @(posedge clk)
    begin
        if (accept && !sample_in.flush)
            load_mem[load_pos_reg] <= {smp_t'(sample_in.sample_real), smp_t'(sample_in.sample_imag)};
        if (state_reg == ST_REV && rev_cnt_reg < count_t'(POINTS))
            ld_rd_reg <= load_mem[addr_t'(rev_cnt_reg)];
    end

    // Result buffer: two read ports, one write port; twiddle ROM read alongside
    always_ff @(posedge clk)
    begin
        if (wr_en)
            res_mem[wr_addr] <= wr_data;
        if (rd_a_en)
            rd_a_reg <= res_mem[rd_a_addr];
        if (rd_b_en)
        begin
            rd_b_reg <= res_mem[hi_addr];
            tw_c_reg <= TW_COS[tw_idx];
            tw_s_reg <= TW_SIN[tw_idx];
        end
    end

    ifft_cmul u_cmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .xr    (acc_t'(rd_b_reg[127:64])),
        .xi    (acc_t'(rd_b_reg[63:0])),
        .c     (tw_c_reg),
        .s     (tw_s_reg),
        .done  (mul_done),
        .tr    (tr),
        .ti    (ti)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            load_pos_reg     <= '0;
            emit_pos_reg     <= '0;
            result_ready_reg <= 1'b0;
            go_xform_reg     <= 1'b0;
            rev_cnt_reg      <= '0;
            bf_cnt_reg       <= '0;
            stage_reg        <= '0;
            out_valid_reg    <= 1'b0;
            last_pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Drop the output beat once taken
            if (out_valid_reg && result_out.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    rev_cnt_reg  <= '0;
                    bf_cnt_reg   <= '0;
                    stage_reg    <= '0;
                    go_xform_reg <= frame_done;
                    if (accept && !sample_in.flush)
                        load_pos_reg <= load_pos_reg + addr_t'(1);
                    if (emitting)
                    begin
                        last_pend_reg <= emit_last;
                        emit_pos_reg  <= emit_pos_reg + addr_t'(1);
                        if (emit_last)
                            result_ready_reg <= 1'b0;
                    end
                end
                ST_FETCH:    out_valid_reg <= 1'b1;
                ST_REV:      rev_cnt_reg <= rev_cnt_reg + count_t'(1);
                ST_BF_WHI:
                begin
                    bf_cnt_reg <= bf_cnt_reg + bfly_t'(1);
                    if (stage_end)
                        stage_reg <= stage_reg + stage_t'(1);
                    if (xform_end)
                    begin
                        result_ready_reg <= 1'b1;
                        emit_pos_reg     <= '0;
                    end
                end
                default:
                begin
                    go_xform_reg <= go_xform_reg;
                end
            endcase
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FETCH)
        begin
            out_real_reg <= ur;
            out_imag_reg <= ui;
            out_last_reg <= last_pend_reg;
        end
    end

    assign result_out.valid    = out_valid_reg;
    assign result_out.out_real = out_real_reg;
    assign result_out.out_imag = out_imag_reg;
    assign result_out.out_last = out_last_reg;

`ifndef ASSERT_OFF
    a_out_from_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FETCH))
        else $error("output beat raised without a result fetch");

    a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ST_BF_MUL)
        else $error("butterfly product finished outside its wait state");

    a_frame_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BF_WHI && xform_end) |=> (result_ready_reg && emit_pos_reg == '0))
        else $error("finished transform not marked as held");

    a_no_emit_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> !(out_valid_reg && !$past(result_out.ready)))
        else $error("result fetched while output register still full");
`endif

endmodule

// ----- verif/tb_inverse_fft_radix2.sv -----
module tb_inverse_fft_radix2;
    import ifft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct {
        acc_t re;
        acc_t im;
        logic last;
    } ifft_sample_t;

    logic clk = 1'b0;
    logic rst_n;

    ifft_in_if  in_ch ();
    ifft_out_if out_ch ();

    inverse_fft_radix2 i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (in_ch),
        .result_out (out_ch)
    );

    // Mirror of the block state
    tw_t          rot_cos [TW_DEPTH];
    tw_t          rot_sin [TW_DEPTH];
    logic [31:0]  frame_re [POINTS];
    logic [31:0]  frame_im [POINTS];
    acc_t         spec_re [POINTS];
    acc_t         spec_im [POINTS];
    int           fill_pos;
    int           drain_pos;
    bit           frame_held;

    ifft_sample_t pending_samples [$];
    int           error_count = 0;
    int           cycle_count = 0;
    bit           burst_mode;

    always #5 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [63:0] q63_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[126:63];
    endfunction

    // Build the rotation table by power series in Q63
    function automatic void make_rotations();
        logic [63:0] ph, quad, frac, arg, x, x2, ts, ss, tc, sc, nn;
        bit          swap;
        tw_t         c0, s0, tmp;
        for (int k = 0; k < TW_DEPTH; k++)
        begin
            ph   = (64'(k) * (64'd1 << (32 - LOG_POINTS))) & 64'hFFFF_FFFF;
            quad = (ph >> 30) & 64'd3;
            frac = ph & 64'h3FFF_FFFF;
            swap = frac > (64'd1 << 29);
            arg  = swap ? (64'd1 << 30) - frac : frac;
            x    = arg * 64'h3_243F_6A89;
            x2   = q63_product(x, x);
            ts   = x;
            ss   = x;
            tc   = 64'd1 << 63;
            sc   = 64'd1 << 63;
            for (int n = 1; n < 24; n++)
            begin
                nn = 64'(n);
                ts = q63_product(ts, x2) / ((2 * nn) * (2 * nn + 1));
                tc = q63_product(tc, x2) / ((2 * nn - 1) * (2 * nn));
                if (n % 2 == 1)
                begin
                    ss = ss - ts;
                    sc = sc - tc;
                end
                else
                begin
                    ss = ss + ts;
                    sc = sc + tc;
                end
            end
            s0 = tw_t'((ss + (64'd1 << 32)) >> 33);
            c0 = tw_t'((sc + (64'd1 << 32)) >> 33);
            if (swap)
            begin
                tmp = c0;
                c0  = s0;
                s0  = tmp;
            end
            case (quad)
                64'd0:
                begin
                    rot_cos[k] = c0;
                    rot_sin[k] = s0;
                end
                64'd1:
                begin
                    rot_cos[k] = -s0;
                    rot_sin[k] = c0;
                end
                64'd2:
                begin
                    rot_cos[k] = -c0;
                    rot_sin[k] = -s0;
                end
                default:
                begin
                    rot_cos[k] = s0;
                    rot_sin[k] = -c0;
                end
            endcase
        end
    endfunction

    function automatic acc_t clamp_sum(input acc_t a, input acc_t b, input bit minus);
        logic signed [64:0] s;
        s = minus ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63])
            return s[64] ? ACC_MIN : ACC_MAX;
        return s[63:0];
    endfunction

    // v * t / 2^30, round half away from zero, clamp
    function automatic acc_t rotate_scale(input acc_t v, input tw_t t);
        logic [63:0] m, u, hi, lo, r;
        bit          neg;
        neg = v[63] != t[31];
        m   = v[63] ? 64'd0 - 64'(v) : 64'(v);
        u   = t[31] ? 64'(-64'(t)) : 64'(t);
        hi  = (m >> 32) * u;
        lo  = (m & 64'hFFFF_FFFF) * u;
        r   = hi * 4 + ((lo + (64'd1 << 29)) >> 30);
        if (!neg)
            return r[63] ? ACC_MAX : acc_t'(r);
        if (r >= (64'd1 << 63))
            return ACC_MIN;
        return acc_t'(64'd0 - r);
    endfunction

    function automatic void run_ifft();
        int   rev, half, stride, lo, hi, k;
        acc_t xr, xi, tr, ti, ur, ui;
        for (int i = 0; i < POINTS; i++)
        begin
            rev = 0;
            for (int b = 0; b < LOG_POINTS; b++)
                rev |= ((i >> b) & 1) << (LOG_POINTS - 1 - b);
            spec_re[rev] = acc_t'(signed'(frame_re[i])) <<< FRACTION_BITS;
            spec_im[rev] = acc_t'(signed'(frame_im[i])) <<< FRACTION_BITS;
        end
        for (int span = 2; span <= POINTS; span <<= 1)
        begin
            half   = span / 2;
            stride = POINTS / span;
            for (int i = 0; i < POINTS; i += span)
            begin
                for (int j = 0; j < half; j++)
                begin
                    lo = i + j;
                    hi = lo + half;
                    k  = (j * stride) % TW_DEPTH;
                    xr = spec_re[hi];
                    xi = spec_im[hi];
                    tr = clamp_sum(rotate_scale(xr, rot_cos[k]),
                                   rotate_scale(xi, rot_sin[k]), 1'b1);
                    ti = clamp_sum(rotate_scale(xi, rot_cos[k]),
                                   rotate_scale(xr, rot_sin[k]), 1'b0);
                    ur = spec_re[lo];
                    ui = spec_im[lo];
                    spec_re[hi] = clamp_sum(ur, tr, 1'b1);
                    spec_im[hi] = clamp_sum(ui, ti, 1'b1);
                    spec_re[lo] = clamp_sum(ur, tr, 1'b0);
                    spec_im[lo] = clamp_sum(ui, ti, 1'b0);
                end
            end
        end
    endfunction

    // Advance the mirror by one accepted beat
    function automatic void predict_beat(input logic [31:0] re, input logic [31:0] im,
                                         input logic flush);
        ifft_sample_t s;
        if (frame_held)
        begin
            s.re   = spec_re[drain_pos];
            s.im   = spec_im[drain_pos];
            s.last = drain_pos == POINTS - 1;
            pending_samples.push_back(s);
            if (s.last)
            begin
                frame_held = 1'b0;
                drain_pos  = 0;
            end
            else
                drain_pos++;
        end
        if (!flush)
        begin
            frame_re[fill_pos] = re;
            frame_im[fill_pos] = im;
            fill_pos++;
            if (fill_pos >= POINTS)
            begin
                run_ifft();
                fill_pos   = 0;
                drain_pos  = 0;
                frame_held = 1'b1;
            end
        end
    endfunction

    function automatic int pick_gap();
        return burst_mode ? 0 : $urandom_range(0, 8);
    endfunction

    // Send one beat; valid stays high when the next beat follows at once
    task automatic send_beat(input logic [31:0] re, input logic [31:0] im, input logic flush);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.sample_real <= re;
        in_ch.sample_imag <= im;
        in_ch.flush       <= flush;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_beat(re, im, flush);
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] corner_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // Flush with nothing held produces no beat
    task automatic test_empty_flush();
        repeat (3) send_beat($urandom, $urandom, 1'b1);
    endtask

    // Frame of extreme values: constant and alternating patterns, then random corner picks
    task automatic test_corner_frame();
        logic [31:0] re, im;
        for (int i = 0; i < POINTS; i++)
        begin
            if (i < 256)
            begin
                re = 32'h7FFF_FFFF;
                im = 32'h8000_0000;
            end
            else if (i < 512)
            begin
                re = i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                im = i[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            else
            begin
                re = corner_value();
                im = corner_value();
            end
            send_beat(re, im, 1'b0);
        end
    endtask

    // Pull a few beats with flushes, then hold off until all arrived
    task automatic test_flush_pause();
        repeat (10) send_beat($urandom, $urandom, 1'b1);
        in_ch.valid <= 1'b0;
        wait_drained();
        @(posedge clk);
    endtask

    // Random samples with flushes mixed in until the held frame has streamed out
    task automatic test_random_frame();
        int n;
        n = 0;
        while (frame_held)
        begin
            if (n % 64 == 0)
                burst_mode = $urandom_range(0, 3) == 0;
            if ($urandom_range(0, 7) == 0)
                send_beat($urandom, $urandom, 1'b1);
            else
                send_beat($urandom, $urandom, 1'b0);
            n++;
        end
        burst_mode = 1'b0;
    endtask

    // Drain the held frame with flush beats
    task automatic test_final_drain();
        int n;
        n = 0;
        while (frame_held)
        begin
            if (n % 64 == 0)
                burst_mode = $urandom_range(0, 3) == 0;
            send_beat($urandom, $urandom, 1'b1);
            n++;
        end
        burst_mode = 1'b0;
        in_ch.valid <= 1'b0;
    endtask

    // Receiver with random stalls
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        ifft_sample_t exp_s;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("unexpected result beat re=%0d im=%0d", out_ch.out_real, out_ch.out_imag);
                error_count++;
            end
            else
            begin
                exp_s = pending_samples.pop_front();
                if (out_ch.out_real !== exp_s.re)
                begin
                    $error("out_real expected %0d actual %0d", exp_s.re, out_ch.out_real);
                    error_count++;
                end
                if (out_ch.out_imag !== exp_s.im)
                begin
                    $error("out_imag expected %0d actual %0d", exp_s.im, out_ch.out_imag);
                    error_count++;
                end
                if (out_ch.out_last !== exp_s.last)
                begin
                    $error("out_last expected %0b actual %0b", exp_s.last, out_ch.out_last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        in_ch.valid       = 1'b0;
        in_ch.sample_real = '0;
        in_ch.sample_imag = '0;
        in_ch.flush       = 1'b0;
        rst_n             = 1'b0;
        burst_mode        = 1'b0;
        fill_pos          = 0;
        drain_pos         = 0;
        frame_held        = 1'b0;
        make_rotations();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_flush();
        test_corner_frame();
        test_flush_pause();
        test_random_frame();
        test_final_drain();

        wait_drained();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
design/ifft_pkg.sv
design/ifft_if.sv
design/ifft_cmul.sv
design/inverse_fft_radix2.sv
verif/tb_inverse_fft_radix2.sv
